[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fpa_pkg.sv]
// Constants, types and helper functions of the fixed-point ALU.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  // Quotient bits resolved by the divider; anything larger is an overflow.
  localparam int QBITS = 33;
  localparam int RW    = 66;
  localparam int NST   = QBITS + 2;

  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_SUB     = 4'd1;
  localparam logic [3:0] OP_MUL     = 4'd2;
  localparam logic [3:0] OP_DIV     = 4'd3;
  localparam logic [3:0] OP_GT      = 4'd4;
  localparam logic [3:0] OP_LT      = 4'd5;
  localparam logic [3:0] OP_GE      = 4'd6;
  localparam logic [3:0] OP_LE      = 4'd7;
  localparam logic [3:0] OP_EQ      = 4'd8;
  localparam logic [3:0] OP_NE      = 4'd9;
  localparam logic [3:0] OP_INC     = 4'd10;
  localparam logic [3:0] OP_DEC     = 4'd11;
  localparam logic [3:0] OP_MIN     = 4'd12;
  localparam logic [3:0] OP_MAX     = 4'd13;
  localparam logic [3:0] OP_TOINT   = 4'd14;
  localparam logic [3:0] OP_FROMINT = 4'd15;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  typedef struct packed {
    logic [3:0]         op;
    logic [31:0]        res;
    logic               cmp;
    logic [1:0]         sts;
    logic signed [63:0] prod;
    logic [RW-1:0]      rem;
    logic [31:0]        dv;
    logic [QBITS-1:0]   q;
    logic               neg;
    logic               ovf;
    logic               dz;
  } pl_t;

  function automatic sat_t sat_signed(input logic signed [63:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = v[31:0];
    if (v > 64'sd2147483647) begin
      s.ovf = 1'b1;
      s.val = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      s.ovf = 1'b1;
      s.val = 32'h8000_0000;
    end
    return s;
  endfunction

  function automatic sat_t sat_mag(input logic [63:0] m, input logic neg);
    sat_t s;
    logic [63:0] lim;
    lim   = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    s.ovf = m > lim;
    if (s.ovf) s.val = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    else       s.val = neg ? (32'd0 - m[31:0]) : m[31:0];
    return s;
  endfunction

endpackage

[hw/rtl/fixed_point_alu.sv]
// Pipelined signed Q-format fixed-point ALU, top level.
// One transfer on the input channel yields exactly one result transfer, in
// order. A new item can be taken in every cycle while in_ready is high. The
// pipeline depth is set by the divider, which resolves one quotient bit per
// stage over 33 stages; all other operations ride along in the same stages
// so results stay in order. The first stage forms sums, compares, shifts and
// the product, the first divider stage also rounds and clamps the product,
// and the last stage rounds and clamps the quotient and is the output
// register. Each stage holds its item while the next stage is full and
// stalled, so a stall at the output fills bubbles first and loses nothing.
// Overflowing results saturate with status 1; divide by zero gives status 2.
module fixed_point_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_operation,
  input  logic [31:0] in_a_raw,
  input  logic [31:0] in_b_raw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_raw,
  output logic        out_compare_true,
  output logic [1:0]  out_status
);
  import fpa_pkg::*;

  pl_t  pl_r   [NST];
  pl_t  pl_nxt [NST];
  logic [NST-1:0] v_r;
  logic [NST:0]   go;

  // A stage may load when it is empty or when its item moves on.
  always_comb begin
    go[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) go[i] = !v_r[i] || go[i+1];
  end
  assign in_ready = go[0];

  // First stage: everything but the divide and the product rounding.
  always_comb begin
    logic signed [63:0] ae, be;
    logic [31:0] ma, mb;
    sat_t s;
    ae = 64'(signed'(in_a_raw));
    be = 64'(signed'(in_b_raw));
    ma = in_a_raw[31] ? 32'd0 - in_a_raw : in_a_raw;
    mb = in_b_raw[31] ? 32'd0 - in_b_raw : in_b_raw;
    s  = '0;
    pl_nxt[0]      = '0;
    pl_nxt[0].op   = in_operation;
    pl_nxt[0].prod = ae * be;
    pl_nxt[0].rem  = RW'(ma) << FRAC_BITS;
    pl_nxt[0].dv   = mb;
    pl_nxt[0].neg  = in_a_raw[31] != in_b_raw[31];
    pl_nxt[0].ovf  = (RW'(ma) << FRAC_BITS) >= (RW'(mb) << QBITS);
    case (in_operation)
      OP_ADD:     s = sat_signed(ae + be);
      OP_SUB:     s = sat_signed(ae - be);
      OP_INC:     s = sat_signed(ae + 64'sd1);
      OP_DEC:     s = sat_signed(ae - 64'sd1);
      OP_FROMINT: s = sat_signed(ae <<< FRAC_BITS);
      default:    s = '0;
    endcase
    pl_nxt[0].res = s.val;
    pl_nxt[0].sts = s.ovf ? ST_OVF : ST_OK;
    case (in_operation)
      OP_GT:    pl_nxt[0].cmp = ae > be;
      OP_LT:    pl_nxt[0].cmp = ae < be;
      OP_GE:    pl_nxt[0].cmp = ae >= be;
      OP_LE:    pl_nxt[0].cmp = ae <= be;
      OP_EQ:    pl_nxt[0].cmp = ae == be;
      OP_NE:    pl_nxt[0].cmp = ae != be;
      OP_MIN:   pl_nxt[0].res = (ae < be) ? in_a_raw : in_b_raw;
      OP_MAX:   pl_nxt[0].res = (ae > be) ? in_a_raw : in_b_raw;
      OP_TOINT: pl_nxt[0].res = 32'($signed(in_a_raw) >>> FRAC_BITS);
      OP_DIV: begin
        if (in_b_raw == 32'd0) begin
          pl_nxt[0].dz  = 1'b1;
          pl_nxt[0].sts = ST_DZ;
          if (in_a_raw[31])           pl_nxt[0].res = 32'h8000_0000;
          else if (in_a_raw != 32'd0) pl_nxt[0].res = 32'h7fff_ffff;
          else                        pl_nxt[0].res = 32'd0;
        end
      end
      default: pl_nxt[0].cmp = 1'b0;
    endcase
  end

  // Divider stages, one quotient bit each, most significant first.
  for (genvar gi = 1; gi <= QBITS; gi++) begin : g_div
    localparam int J = QBITS - gi;
    always_comb begin
      logic [RW-1:0] trial;
      logic [63:0]   mm;
      sat_t          ms;
      trial = RW'(pl_r[gi-1].dv) << J;
      mm    = '0;
      ms    = '0;
      pl_nxt[gi] = pl_r[gi-1];
      if (pl_r[gi-1].rem >= trial) begin
        pl_nxt[gi].rem  = pl_r[gi-1].rem - trial;
        pl_nxt[gi].q[J] = 1'b1;
      end
      if (gi == 1 && pl_r[gi-1].op == OP_MUL) begin
        mm = pl_r[gi-1].prod[63] ? 64'd0 - pl_r[gi-1].prod : pl_r[gi-1].prod;
        mm = (mm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        ms = sat_mag(mm, pl_r[gi-1].prod[63]);
        pl_nxt[gi].res = ms.val;
        pl_nxt[gi].sts = ms.ovf ? ST_OVF : ST_OK;
      end
    end
  end

  // Last stage: round the quotient half away from zero and clamp.
  always_comb begin
    logic        rnd;
    logic [63:0] qr;
    sat_t        ds;
    pl_t         p;
    p   = pl_r[NST-2];
    rnd = {p.rem[32:0], 1'b0} >= {2'b00, p.dv};
    qr  = 64'(p.q) + 64'(rnd);
    ds  = sat_mag(qr, p.neg);
    pl_nxt[NST-1] = p;
    if (p.op == OP_DIV && !p.dz) begin
      pl_nxt[NST-1].res = ds.val;
      pl_nxt[NST-1].sts = (ds.ovf || p.ovf) ? ST_OVF : ST_OK;
      if (p.ovf) pl_nxt[NST-1].res = p.neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (go[i]) pl_r[i] <= pl_nxt[i];
    end
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (go[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (go[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign out_valid        = v_r[NST-1];
  assign out_result_raw   = pl_r[NST-1].res;
  assign out_compare_true = pl_r[NST-1].cmp;
  assign out_status       = pl_r[NST-1].sts;

endmodule

[hw/rtl/fpa_checker.sv]
// Port-level checker of the fixed-point ALU and its bind.
`include "assert_macros.svh"
module fpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_raw,
  input logic        out_compare_true,
  input logic [1:0]  out_status
);
  import fpa_pkg::*;

  `AST_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_result_raw), "result dropped")
  `AST_IMPLY(a_sts, out_valid, out_status != 2'd3, "bad status code")
  `AST_IMPLY(a_cmp, out_valid && out_compare_true, out_result_raw == 32'd0 && out_status == ST_OK, "compare result not clean")
  `AST_IMPLY(a_ovf, out_valid && out_status == ST_OVF, out_result_raw == 32'h7fff_ffff || out_result_raw == 32'h8000_0000, "overflow not saturated")

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_result_raw(out_result_raw), .out_compare_true(out_compare_true),
  .out_status(out_status)
);

[bench/tb_top.sv]
// Self-checking testbench for the pipelined fixed-point ALU.
`timescale 1ns / 1ps

module tb_top;
  import fpa_pkg::*;

  // One operation request as it crosses the input channel.
  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  // One answer as it leaves the result channel.
  typedef struct {
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  sts;
  } alu_ans_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_operation;
  logic [31:0] in_a_raw;
  logic [31:0] in_b_raw;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_result_raw;
  logic        out_compare_true;
  logic [1:0]  out_status;

  alu_req_t pending_reqs[$];
  alu_ans_t expected_answers[$];
  int       error_count;
  bit       long_hold_done;
  logic     in_taken;

  fixed_point_alu u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_a_raw         (in_a_raw),
    .in_b_raw         (in_b_raw),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_raw   (out_result_raw),
    .out_compare_true (out_compare_true),
    .out_status       (out_status)
  );

  always #2 clk = ~clk;

  // Clamps an exact value to the signed 32-bit range and marks overflow.
  function automatic void clamp_word(input logic signed [65:0] v, inout alu_ans_t ans);
    if (v > 66'sd2147483647) begin
      ans.res = 32'h7fff_ffff;
      ans.sts = ST_OVF;
    end else if (v < -66'sd2147483648) begin
      ans.res = 32'h8000_0000;
      ans.sts = ST_OVF;
    end else begin
      ans.res = v[31:0];
    end
  endfunction

  // Computes the exact answer of the ALU for one request. Multiply and
  // divide work on magnitudes and round half away from zero.
  function automatic alu_ans_t compute_answer(input alu_req_t req);
    alu_ans_t           ans;
    logic signed [65:0] a;
    logic signed [65:0] b;
    logic signed [65:0] prod;
    logic [65:0]        mag;
    logic [65:0]        num;
    logic [65:0]        den;
    logic [65:0]        quo;
    logic [65:0]        rem;
    logic               neg;
    a = {{34{req.a[31]}}, req.a};
    b = {{34{req.b[31]}}, req.b};
    ans.res = '0;
    ans.cmp = 1'b0;
    ans.sts = ST_OK;
    case (req.op)
      OP_ADD: clamp_word(a + b, ans);
      OP_SUB: clamp_word(a - b, ans);
      OP_MUL: begin
        prod = a * b;
        neg  = prod < 0;
        mag  = neg ? -prod : prod;
        mag  = (mag + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        clamp_word(neg ? -$signed(mag) : $signed(mag), ans);
      end
      OP_DIV: begin
        if (b == 0) begin
          ans.sts = ST_DZ;
          if (a > 0) ans.res = 32'h7fff_ffff;
          else if (a < 0) ans.res = 32'h8000_0000;
        end else begin
          num = (a < 0 ? -a : a) << FRAC_BITS;
          den = b < 0 ? -b : b;
          quo = num / den;
          rem = num % den;
          if (rem >= den - rem) quo = quo + 1;
          neg = (a < 0) != (b < 0);
          clamp_word(neg ? -$signed(quo) : $signed(quo), ans);
        end
      end
      OP_GT: ans.cmp = a > b;
      OP_LT: ans.cmp = a < b;
      OP_GE: ans.cmp = a >= b;
      OP_LE: ans.cmp = a <= b;
      OP_EQ: ans.cmp = a == b;
      OP_NE: ans.cmp = a != b;
      OP_INC: clamp_word(a + 1, ans);
      OP_DEC: clamp_word(a - 1, ans);
      OP_MIN: ans.res = (a < b) ? req.a : req.b;
      OP_MAX: ans.res = (a > b) ? req.a : req.b;
      OP_TOINT: ans.res = 32'($signed(req.a) >>> FRAC_BITS);
      default: clamp_word(a <<< FRAC_BITS, ans);
    endcase
    return ans;
  endfunction

  function automatic logic [31:0] random_operand();
    // Mix extremes, small values and full-range noise.
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff - $urandom_range(0, 2);
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3: return 32'($signed($urandom_range(0, 131072)) - 65536);
      4: return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    alu_req_t req;
    req.op = op;
    req.a  = a;
    req.b  = b;
    pending_reqs.push_back(req);
  endtask

  initial begin
    logic [31:0] a;
    clk           = 1'b0;
    rst_n         = 1'b0;
    error_count   = 0;
    // Directed part: extremes, every operation and the named special cases.
    queue_req(OP_ADD, 32'h7fff_ffff, 32'd1);
    queue_req(OP_ADD, 32'h8000_0000, 32'hffff_ffff);
    queue_req(OP_SUB, 32'h8000_0000, 32'd1);
    queue_req(OP_SUB, 32'h7fff_ffff, 32'h8000_0000);
    queue_req(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_req(OP_MUL, 32'h0000_0180, 32'hffff_ff80);
    queue_req(OP_MUL, 32'h0000_0001, 32'h0000_0080);
    queue_req(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_req(OP_DIV, 32'h0000_0100, 32'd0);
    queue_req(OP_DIV, 32'hffff_ff00, 32'd0);
    queue_req(OP_DIV, 32'd0, 32'd0);
    queue_req(OP_DIV, 32'h8000_0000, 32'h0000_0001);
    queue_req(OP_DIV, 32'h0000_0001, 32'hffff_fe00);
    queue_req(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    for (int op = OP_GT; op <= OP_NE; op++) queue_req(op[3:0], 32'h8000_0000, 32'h7fff_ffff);
    queue_req(OP_EQ, 32'h1234_5678, 32'h1234_5678);
    queue_req(OP_INC, 32'h7fff_ffff, 32'd0);
    queue_req(OP_DEC, 32'h8000_0000, 32'hffff_ffff);
    queue_req(OP_MIN, 32'h0000_0055, 32'h0000_0055);
    queue_req(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    queue_req(OP_TOINT, 32'hffff_ff01, 32'd0);
    queue_req(OP_FROMINT, 32'h0080_0000, 32'd0);
    queue_req(OP_FROMINT, 32'hff7f_ffff, 32'd0);
    // Random part: every opcode, operands from all classes.
    for (int i = 0; i < 450; i++) begin
      a = random_operand();
      queue_req(4'($urandom_range(0, 15)), a, ($urandom_range(0, 5) == 0) ? a : random_operand());
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_answers.size() == 0);
    // The pipeline is 35 stages deep; give it time to show any stray result.
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("fixed_point_alu test passed");
    end else begin
      $display("fixed_point_alu test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("fixed_point_alu test failed");
    $finish;
  end

  // Records whether the input transfer happened at the last rising edge.
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // Sender: bursts of random length separated by random gaps. Valid stays up
  // with a stable payload until the transfer happens.
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_operation <= '0;
      in_a_raw     <= '0;
      in_b_raw     <= '0;
      burst_left   <= $urandom_range(1, 20);
      gap_left     <= 0;
    end else if (!in_valid || in_taken) begin
      // The previous item, if any, was taken at the last rising edge.
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_valid     <= 1'b1;
        in_operation <= pending_reqs[0].op;
        in_a_raw     <= pending_reqs[0].a;
        in_b_raw     <= pending_reqs[0].b;
        void'(pending_reqs.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off early in the run
  // so that the pipeline fills and pushes back on the sender.
  int hold_cycles;
  int recv_phase;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready      <= 1'b0;
      hold_cycles    <= 0;
      recv_phase     <= 0;
      long_hold_done <= 1'b0;
    end else begin
      recv_phase <= recv_phase + 1;
      if (!long_hold_done && recv_phase == 60) begin
        hold_cycles    <= 150;
        long_hold_done <= 1'b1;
        out_ready      <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready   <= 1'b0;
      end else if ((recv_phase / 64) % 3 == 2) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= (recv_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor: every input transfer adds an expectation, every output transfer
  // is checked against the oldest one.
  always @(posedge clk) begin
    alu_req_t req;
    alu_ans_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        req.op = in_operation;
        req.a  = in_a_raw;
        req.b  = in_b_raw;
        expected_answers.push_back(compute_answer(req));
      end
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result %h cmp %b status %0d", $realtime,
                   out_result_raw, out_compare_true, out_status);
          error_count++;
        end else begin
          want = expected_answers.pop_front();
          if (out_result_raw !== want.res) begin
            $display("%0t: result expected %h actual %h", $realtime, want.res, out_result_raw);
            error_count++;
          end
          if (out_compare_true !== want.cmp) begin
            $display("%0t: compare expected %b actual %b", $realtime, want.cmp,
                     out_compare_true);
            error_count++;
          end
          if (out_status !== want.sts) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.sts, out_status);
            error_count++;
          end
        end
      end
    end
  end

endmodule
